// ===== sv/sbau_pkg.sv =====
// Package: widths, codes and shared types of the slice bandwidth admission unit.
`default_nettype none

package sbau_pkg;

    localparam int RATE_W  = 40;
    localparam int ID_W    = 64;
    localparam int DRIFT_W = 41;
    localparam int WORD_W  = 43;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int IDX_W   = 3;

    localparam logic       CMD_RESERVE = 1'b0;
    localparam logic       CMD_RELEASE = 1'b1;

    localparam logic [1:0] SLICE_DEF = 2'd0;
    localparam logic [1:0] SLICE_GBR = 2'd1;
    localparam logic [1:0] SLICE_MTC = 2'd2;
    localparam logic [1:0] SLICE_BAD = 2'd3;

    localparam logic [IDX_W-1:0] REG_LINK_RATE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SLICING_ON = 3'd1;
    localparam logic [IDX_W-1:0] REG_GBR_CAP    = 3'd2;
    localparam logic [IDX_W-1:0] REG_MTC_CAP    = 3'd3;
    localparam logic [IDX_W-1:0] REG_THRESHOLD  = 3'd4;
    localparam logic [IDX_W-1:0] REG_FULL_DUPLEX = 3'd5;
    localparam logic [IDX_W-1:0] REG_SECOND_ID  = 3'd6;
    localparam logic [IDX_W-1:0] REG_UNUSED     = 3'd7;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [RATE_W-1:0] link_rate;
        logic              slicing_on;
        logic [RATE_W-1:0] gbr_cap;
        logic [RATE_W-1:0] mtc_cap;
        logic [RATE_W-1:0] adjust_threshold;
        logic              full_duplex;
        logic [ID_W-1:0]   second_switch_id;
    } t_cfg;

    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   source_id;
        logic [1:0]        slice_sel;
        logic [RATE_W-1:0] amount;
    } t_req;

    typedef struct packed {
        logic              accepted;
        logic              backward;
        logic [RATE_W-1:0] slice_reserved;
        logic [RATE_W-1:0] meter_rate;
        logic              meter_adjust;
    } t_rsp;

    typedef struct packed {
        t_word a;
        t_word b;
        logic  sub;
    } t_alu_req;

endpackage

`default_nettype wire

// ===== sv/sbau_ifs.sv =====
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none

interface sbau_req_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [sbau_pkg::ID_W-1:0]   source_id;
    logic [1:0]                  slice_sel;
    logic [sbau_pkg::RATE_W-1:0] amount;

    modport source (output valid, cmd, source_id, slice_sel, amount, input ready);
    modport sink   (input valid, cmd, source_id, slice_sel, amount, output ready);
endinterface

interface sbau_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic                        backward;
    logic [sbau_pkg::RATE_W-1:0] slice_reserved;
    logic [sbau_pkg::RATE_W-1:0] meter_rate;
    logic                        meter_adjust;

    modport source (output valid, accepted, backward, slice_reserved, meter_rate,
                    meter_adjust, input ready);
    modport sink   (input valid, accepted, backward, slice_reserved, meter_rate,
                    meter_adjust, output ready);
endinterface

`default_nettype wire

// ===== sv/slice_bandwidth_admission_unit.sv =====
// Top level: slice bandwidth admission unit with APB configuration port.
//
//  channel  dir  handshake         payload
//  i_req    in   valid/ready       cmd, source_id, slice_sel, amount
//  o_rsp    out  valid/ready       accepted, backward, slice_reserved, meter_rate,
//                                  meter_adjust
//  apb      in   psel/penable      paddr[5:3] register index, pwdata/prdata 64 bits
//
//  One 43-bit adder is shared by every step, so the steps run one after another;
//  a refused item skips the drift steps and an invalid slice skips to the totals.
//  Reset clears the slice reservations and both drifts at once; no sweep.
//  A result beat waits in the output register; the next request is taken meanwhile,
//  and its result holds in the last step until the register frees.
`default_nettype none

module slice_bandwidth_admission_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    sbau_req_if.sink                     i_req,
    sbau_rsp_if.source                   o_rsp,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [sbau_pkg::ADDR_W-1:0]   paddr,
    input  wire [sbau_pkg::DATA_W-1:0]   pwdata,
    output logic [sbau_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    sbau_pkg::t_cfg      cfg;
    sbau_pkg::t_req      req;
    sbau_pkg::t_rsp      rsp;
    sbau_pkg::t_alu_req  alu_req;
    sbau_pkg::t_word     alu_sum;
    logic                in_ready;
    logic                out_valid;

    assign req.cmd       = i_req.cmd;
    assign req.source_id = i_req.source_id;
    assign req.slice_sel = i_req.slice_sel;
    assign req.amount    = i_req.amount;
    assign i_req.ready   = in_ready;

    assign o_rsp.valid          = out_valid;
    assign o_rsp.accepted       = rsp.accepted;
    assign o_rsp.backward       = rsp.backward;
    assign o_rsp.slice_reserved = rsp.slice_reserved;
    assign o_rsp.meter_rate     = rsp.meter_rate;
    assign o_rsp.meter_adjust   = rsp.meter_adjust;

    sbau_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sbau_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    sbau_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .i_req       (req),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_rsp       (rsp),
        .o_alu       (alu_req),
        .i_alu_sum   (alu_sum)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && in_ready) |=> !in_ready)
        else $error("request taken while a request is in work");

    a_adjust_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && rsp.meter_adjust) |-> rsp.accepted)
        else $error("meter adjust on a refused request");

    a_backward_needs_duplex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && rsp.backward) |-> cfg.full_duplex)
        else $error("backward direction on a half-duplex link");

endmodule

`default_nettype wire

// ===== sv/sbau_alu.sv =====
// Shared 43-bit adder/subtractor used by every step of the sequencer.
`default_nettype none

module sbau_alu (
    input  var sbau_pkg::t_alu_req i_req,
    output sbau_pkg::t_word        o_sum
);

    sbau_pkg::t_word operand_b;

    assign operand_b = i_req.sub ? ~i_req.b : i_req.b;
    assign o_sum     = i_req.a + operand_b + {{(sbau_pkg::WORD_W-1){1'b0}}, i_req.sub};

endmodule

`default_nettype wire

// ===== sv/sbau_cfg.sv =====
// APB register file holding link rate, slice caps, threshold and direction setup.
`default_nettype none

module sbau_cfg (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [sbau_pkg::ADDR_W-1:0]    paddr,
    input  wire [sbau_pkg::DATA_W-1:0]    pwdata,
    output logic [sbau_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output sbau_pkg::t_cfg                o_cfg
);

    sbau_pkg::t_cfg                 r_cfg;
    logic [sbau_pkg::IDX_W-1:0]     reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[sbau_pkg::ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_rate        <= '0;
            r_cfg.slicing_on       <= 1'b0;
            r_cfg.gbr_cap          <= '0;
            r_cfg.mtc_cap          <= '0;
            r_cfg.adjust_threshold <= '0;
            r_cfg.full_duplex      <= 1'b1;
            r_cfg.second_switch_id <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                sbau_pkg::REG_LINK_RATE: begin
                    r_cfg.link_rate <= pwdata[sbau_pkg::RATE_W-1:0];
                end
                sbau_pkg::REG_SLICING_ON: begin
                    r_cfg.slicing_on <= pwdata[0];
                end
                sbau_pkg::REG_GBR_CAP: begin
                    r_cfg.gbr_cap <= pwdata[sbau_pkg::RATE_W-1:0];
                end
                sbau_pkg::REG_MTC_CAP: begin
                    r_cfg.mtc_cap <= pwdata[sbau_pkg::RATE_W-1:0];
                end
                sbau_pkg::REG_THRESHOLD: begin
                    r_cfg.adjust_threshold <= pwdata[sbau_pkg::RATE_W-1:0];
                end
                sbau_pkg::REG_FULL_DUPLEX: begin
                    r_cfg.full_duplex <= pwdata[0];
                end
                sbau_pkg::REG_SECOND_ID: begin
                    r_cfg.second_switch_id <= pwdata;
                end
                sbau_pkg::REG_UNUSED: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            sbau_pkg::REG_LINK_RATE:   prdata[sbau_pkg::RATE_W-1:0] = r_cfg.link_rate;
            sbau_pkg::REG_SLICING_ON:  prdata[0] = r_cfg.slicing_on;
            sbau_pkg::REG_GBR_CAP:     prdata[sbau_pkg::RATE_W-1:0] = r_cfg.gbr_cap;
            sbau_pkg::REG_MTC_CAP:     prdata[sbau_pkg::RATE_W-1:0] = r_cfg.mtc_cap;
            sbau_pkg::REG_THRESHOLD:   prdata[sbau_pkg::RATE_W-1:0] = r_cfg.adjust_threshold;
            sbau_pkg::REG_FULL_DUPLEX: prdata[0] = r_cfg.full_duplex;
            sbau_pkg::REG_SECOND_ID:   prdata = r_cfg.second_switch_id;
            sbau_pkg::REG_UNUSED:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/sbau_core.sv =====
// Sequencer and state: slice reservations, drift, and the output register.
`default_nettype none

module sbau_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  var sbau_pkg::t_cfg      i_cfg,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  var sbau_pkg::t_req      i_req,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output sbau_pkg::t_rsp          o_rsp,
    output sbau_pkg::t_alu_req      o_alu,
    input  var sbau_pkg::t_word     i_alu_sum
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIR  = 4'd1;
    localparam logic [3:0] S_CAP  = 4'd2;
    localparam logic [3:0] S_NEW  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_DRF  = 4'd5;
    localparam logic [3:0] S_ABS  = 4'd6;
    localparam logic [3:0] S_THR  = 4'd7;
    localparam logic [3:0] S_TOT0 = 4'd8;
    localparam logic [3:0] S_TOT1 = 4'd9;
    localparam logic [3:0] S_TOT2 = 4'd10;
    localparam logic [3:0] S_MET  = 4'd11;

    localparam int RW = sbau_pkg::RATE_W;
    localparam int WW = sbau_pkg::WORD_W;
    localparam int DW = sbau_pkg::DRIFT_W;

    logic [3:0]                 r_state;
    logic                       r_cmd;
    logic [sbau_pkg::ID_W-1:0]  r_src;
    logic [1:0]                 r_slice;
    logic [RW-1:0]              r_amount;
    logic                       r_dir;
    sbau_pkg::t_word            r_tmp;
    sbau_pkg::t_word            r_new;
    logic [RW-1:0]              r_cap;
    logic                       r_ok;
    logic                       r_pulse;
    logic [RW-1:0]              r_res;
    logic [RW-1:0]              r_rsv [0:5];
    logic [DW-1:0]              r_drift [0:1];
    logic                       r_ov;
    sbau_pkg::t_rsp             r_rsp;

    logic [sbau_pkg::IDX_W-1:0] rd_addr;
    logic [RW-1:0]              rd_data;
    logic                       sum_neg;
    logic                       out_free;
    logic                       chk_ok;
    logic [RW-1:0]              n_cap;
    logic [DW-1:0]              drift_cur;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_rsp       = r_rsp;
    assign sum_neg     = i_alu_sum[WW-1];
    assign out_free    = !r_ov || i_out_ready;
    assign rd_data     = r_rsv[rd_addr];
    assign drift_cur   = r_drift[r_dir];
    assign chk_ok      = (r_cmd == sbau_pkg::CMD_RELEASE) ? !r_new[WW-1] : !sum_neg;

    always_comb begin
        unique case (r_state)
            S_TOT0:  rd_addr = {sbau_pkg::SLICE_DEF, r_dir};
            S_TOT1:  rd_addr = {sbau_pkg::SLICE_GBR, r_dir};
            S_TOT2:  rd_addr = {sbau_pkg::SLICE_MTC, r_dir};
            default: rd_addr = {r_slice, r_dir};
        endcase
    end

    always_comb begin
        o_alu.a   = '0;
        o_alu.b   = '0;
        o_alu.sub = 1'b0;
        unique case (r_state)
            S_DIR: begin
                o_alu.a = {3'b000, i_cfg.gbr_cap};
                o_alu.b = {3'b000, i_cfg.mtc_cap};
            end
            S_CAP: begin
                o_alu.a   = {3'b000, i_cfg.link_rate};
                o_alu.b   = r_tmp;
                o_alu.sub = 1'b1;
            end
            S_NEW: begin
                o_alu.a   = {3'b000, rd_data};
                o_alu.b   = {3'b000, r_amount};
                o_alu.sub = (r_cmd == sbau_pkg::CMD_RELEASE);
            end
            S_CHK: begin
                o_alu.a   = {3'b000, r_cap};
                o_alu.b   = r_new;
                o_alu.sub = 1'b1;
            end
            S_DRF: begin
                o_alu.a   = {{(WW-DW){drift_cur[DW-1]}}, drift_cur};
                o_alu.b   = {3'b000, r_amount};
                o_alu.sub = (r_cmd == sbau_pkg::CMD_RESERVE);
            end
            S_ABS: begin
                o_alu.a   = r_new[WW-1] ? '0 : r_new;
                o_alu.b   = r_new[WW-1] ? r_new : '0;
                o_alu.sub = r_new[WW-1];
            end
            S_THR: begin
                o_alu.a   = r_tmp;
                o_alu.b   = {3'b000, i_cfg.adjust_threshold};
                o_alu.sub = 1'b1;
            end
            S_TOT0: begin
                o_alu.b = {3'b000, rd_data};
            end
            S_TOT1, S_TOT2: begin
                o_alu.a = r_tmp;
                o_alu.b = {3'b000, rd_data};
            end
            S_MET: begin
                o_alu.a   = {3'b000, i_cfg.link_rate};
                o_alu.b   = r_tmp;
                o_alu.sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (!i_cfg.slicing_on) begin
            n_cap = (r_slice == sbau_pkg::SLICE_DEF) ? i_cfg.link_rate : '0;
        end else begin
            unique case (r_slice)
                sbau_pkg::SLICE_GBR: n_cap = i_cfg.gbr_cap;
                sbau_pkg::SLICE_MTC: n_cap = i_cfg.mtc_cap;
                default:             n_cap = sum_neg ? '0 : i_alu_sum[RW-1:0];
            endcase
        end
    end

    // control state and slice accounting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_rsv[i] <= '0;
            end
            r_drift[0] <= '0;
            r_drift[1] <= '0;
        end else begin
            if (r_state == S_MET && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DIR;
                    end
                end
                S_DIR: begin
                    r_state <= (r_slice == sbau_pkg::SLICE_BAD) ? S_TOT0 : S_CAP;
                end
                S_CAP: r_state <= S_NEW;
                S_NEW: r_state <= S_CHK;
                S_CHK: begin
                    if (chk_ok) begin
                        r_rsv[rd_addr] <= r_new[RW-1:0];
                        r_state        <= S_DRF;
                    end else begin
                        r_state <= S_TOT0;
                    end
                end
                S_DRF: r_state <= S_ABS;
                S_ABS: r_state <= S_THR;
                S_THR: begin
                    r_drift[r_dir] <= sum_neg ? r_new[DW-1:0] : '0;
                    r_state        <= S_TOT0;
                end
                S_TOT0: r_state <= S_TOT1;
                S_TOT1: r_state <= S_TOT2;
                S_TOT2: r_state <= S_MET;
                S_MET: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working registers and result beat
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_cmd    <= i_req.cmd;
                    r_src    <= i_req.source_id;
                    r_slice  <= i_req.slice_sel;
                    r_amount <= i_req.amount;
                end
            end
            S_DIR: begin
                r_dir   <= i_cfg.full_duplex && (r_src == i_cfg.second_switch_id);
                r_tmp   <= i_alu_sum;
                r_ok    <= 1'b0;
                r_pulse <= 1'b0;
                r_res   <= '0;
            end
            S_CAP: r_cap <= n_cap;
            S_NEW: r_new <= i_alu_sum;
            S_CHK: begin
                r_ok  <= chk_ok;
                r_res <= chk_ok ? r_new[RW-1:0] : rd_data;
            end
            S_DRF: r_new <= i_alu_sum;
            S_ABS: r_tmp <= i_alu_sum;
            S_THR: r_pulse <= !sum_neg;
            S_TOT0, S_TOT1, S_TOT2: r_tmp <= i_alu_sum;
            S_MET: begin
                if (out_free) begin
                    r_rsp.accepted       <= r_ok;
                    r_rsp.backward       <= r_dir;
                    r_rsp.slice_reserved <= r_res;
                    r_rsp.meter_rate     <= sum_neg ? '0 : i_alu_sum[RW-1:0];
                    r_rsp.meter_adjust   <= r_pulse;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
